/* hdl/ofd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the orthonormal frame block.
// No dependencies; every other file depends on this package.
package ofd_pkg;

  // Reduced magnitudes stay below 2^RED_W before squaring.
  localparam int RED_W  = 24;
  localparam int Q_W    = 16;            // Q1.14 output width
  localparam int QW     = Q_W - 1;       // quotient magnitude bits
  localparam int DIR_W  = 33;            // difference magnitude width
  localparam int PERP_W = RED_W + 1;
  localparam int SIDE_W = 2 * RED_W + 1;
  localparam int PROD_W = 2 * RED_W;

  // Normalizer depth: mask, shift select, shift, square, sum,
  // one square-root bit per stage, divider setup, one quotient bit
  // per stage, sign/output.
  localparam int NORM_STAGES = 5 + (RED_W + 1) + 1 + QW + 1;
  localparam int TOP_LATENCY = 5 + 2 * NORM_STAGES;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
  } pts_t;

  typedef struct packed {
    logic signed [Q_W-1:0] dir_x;
    logic signed [Q_W-1:0] dir_y;
    logic signed [Q_W-1:0] dir_z;
    logic signed [Q_W-1:0] perp_x;
    logic signed [Q_W-1:0] perp_y;
    logic signed [Q_W-1:0] perp_z;
    logic signed [Q_W-1:0] side_x;
    logic signed [Q_W-1:0] side_y;
    logic signed [Q_W-1:0] side_z;
    logic                  degenerate;
  } frame_t;

endpackage

/* hdl/ofd_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for point pairs and frames.
// Depends on ofd_pkg for the payload types.
interface ofd_pts_if;
  logic          valid;
  logic          ready;
  ofd_pkg::pts_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ofd_frame_if;
  logic            valid;
  logic            ready;
  ofd_pkg::frame_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/orthonormal_frame_from_direction_top.sv */
`timescale 1ns / 1ps
// Orthonormal frame from two Q16.16 points; Q1.14 columns out.
// Pipeline: two normalizers of 47 stages each, deepened by the
// one-bit-per-stage square root and dividers. Accepts one beat
// per cycle while the output is not stalled.
// Synchronous active-high reset clears all stage valid bits.
// Depends on ofd_pkg, ofd_if, ofd_norm.
module orthonormal_frame_from_direction_top (
  input logic         clk,
  input logic         rst,
  ofd_pts_if.sink     pts,
  ofd_frame_if.source frame
);
  import ofd_pkg::*;

  logic adv;
  assign adv       = !frame.valid || frame.ready;
  assign pts.ready = adv;

  // T0: differences
  logic                 v0;
  logic [2:0][DIR_W-1:0] d0, d_next;
  // T1: sign/magnitude
  logic                 v1, deg1;
  logic [2:0]           neg1;
  logic [2:0][DIR_W-1:0] mag1;
  // direction normalizer
  logic                  dv;
  logic [2:0]            dneg;
  logic [2:0][RED_W-1:0] dred;
  logic [2:0][Q_W-1:0]   dq;
  logic                  ddeg;
  // T2: products
  logic                  v2, br2, deg2;
  logic [2:0]            ng2;
  logic [2:0][RED_W-1:0] rd2;
  logic [2:0][Q_W-1:0]   dq2;
  logic [PROD_W-1:0]     pxz, pyz, pxx, pyy, pzz, pxy;
  // T3: perp and side vectors
  logic                   v3, deg3;
  logic [2:0]             pneg3, cneg3;
  logic [2:0][PERP_W-1:0] pmag3;
  logic [2:0][SIDE_W-1:0] cmag3;
  logic [2:0][Q_W-1:0]    dq3;
  // second-level normalizers
  logic                  pv, pdeg;
  logic [2:0][Q_W-1:0]   pq, cq, cdq;

  always_comb begin
    d_next[0] = {pts.data.end_x[31], pts.data.end_x} - {pts.data.start_x[31], pts.data.start_x};
    d_next[1] = {pts.data.end_y[31], pts.data.end_y} - {pts.data.start_y[31], pts.data.start_y};
    d_next[2] = {pts.data.end_z[31], pts.data.end_z} - {pts.data.start_z[31], pts.data.start_z};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0          <= 1'b0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      frame.valid <= 1'b0;
    end else if (adv) begin
      v0          <= pts.valid;
      v1          <= v0;
      v2          <= dv;
      v3          <= v2;
      frame.valid <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d0   <= d_next;
      deg1 <= (d0 == '0);
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= d0[i][DIR_W-1];
        mag1[i] <= d0[i][DIR_W-1] ? -d0[i] : d0[i];
      end

      br2  <= (dred[0] != '0) || (dred[1] != '0);
      ng2  <= dneg;
      rd2  <= dred;
      dq2  <= dq;
      deg2 <= ddeg;
      pxz  <= PROD_W'(dred[0]) * PROD_W'(dred[2]);
      pyz  <= PROD_W'(dred[1]) * PROD_W'(dred[2]);
      pxx  <= PROD_W'(dred[0]) * PROD_W'(dred[0]);
      pyy  <= PROD_W'(dred[1]) * PROD_W'(dred[1]);
      pzz  <= PROD_W'(dred[2]) * PROD_W'(dred[2]);
      pxy  <= PROD_W'(dred[0]) * PROD_W'(dred[1]);

      dq3  <= dq2;
      deg3 <= deg2;
      if (br2) begin
        // perp = (ay, -ax, 0); side = (-ax*az, -ay*az, ax^2 + ay^2)
        pmag3 <= {PERP_W'(0), PERP_W'(rd2[0]), PERP_W'(rd2[1])};
        pneg3 <= {1'b0, !ng2[0], ng2[1]};
        cmag3 <= {SIDE_W'(pxx) + SIDE_W'(pyy), SIDE_W'(pyz), SIDE_W'(pxz)};
        cneg3 <= {1'b0, !(ng2[1] ^ ng2[2]), !(ng2[0] ^ ng2[2])};
      end else begin
        // perp = (az, 0, -ax); side = (ax*ay, -(ax^2 + az^2), az*ay)
        pmag3 <= {PERP_W'(rd2[0]), PERP_W'(0), PERP_W'(rd2[2])};
        pneg3 <= {!ng2[0], 1'b0, ng2[2]};
        cmag3 <= {SIDE_W'(pyz), SIDE_W'(pxx) + SIDE_W'(pzz), SIDE_W'(pxy)};
        cneg3 <= {ng2[2] ^ ng2[1], 1'b1, ng2[0] ^ ng2[1]};
      end

      frame.data.degenerate <= pdeg;
      frame.data.dir_x  <= pdeg ? '0 : cdq[0];
      frame.data.dir_y  <= pdeg ? '0 : cdq[1];
      frame.data.dir_z  <= pdeg ? '0 : cdq[2];
      frame.data.perp_x <= pdeg ? '0 : pq[0];
      frame.data.perp_y <= pdeg ? '0 : pq[1];
      frame.data.perp_z <= pdeg ? '0 : pq[2];
      frame.data.side_x <= pdeg ? '0 : cq[0];
      frame.data.side_y <= pdeg ? '0 : cq[1];
      frame.data.side_z <= pdeg ? '0 : cq[2];
    end
  end

  ofd_norm #(.MW(DIR_W), .SW(1)) u_dir (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vld_in   (v1),
    .neg_in   (neg1),
    .mag_in   (mag1),
    .side_in  (deg1),
    .vld_out  (dv),
    .neg_out  (dneg),
    .red_out  (dred),
    .q_out    (dq),
    .side_out (ddeg)
  );

  ofd_norm #(.MW(PERP_W), .SW(1)) u_perp (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vld_in   (v3),
    .neg_in   (pneg3),
    .mag_in   (pmag3),
    .side_in  (deg3),
    .vld_out  (pv),
    .neg_out  (),
    .red_out  (),
    .q_out    (pq),
    .side_out (pdeg)
  );

  ofd_norm #(.MW(SIDE_W), .SW(3 * Q_W)) u_side (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vld_in   (v3),
    .neg_in   (cneg3),
    .mag_in   (cmag3),
    .side_in  (dq3),
    .vld_out  (),
    .neg_out  (),
    .red_out  (),
    .q_out    (cq),
    .side_out (cdq)
  );

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    frame.valid && frame.data.degenerate |->
      frame.data.dir_x == '0 && frame.data.dir_y == '0 && frame.data.dir_z == '0 &&
      frame.data.side_y == '0)
    else $error("degenerate beat with nonzero columns");

  a_dir_unit: assert property (@(posedge clk) disable iff (rst)
    frame.valid && !frame.data.degenerate |->
      frame.data.dir_x <= 16'sd16384 && frame.data.dir_x >= -16'sd16384 &&
      frame.data.side_z <= 16'sd16384 && frame.data.side_z >= -16'sd16384)
    else $error("unit column out of Q1.14 range");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    pts.valid && pts.ready |=> v0)
    else $error("accepted beat did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v1) && $stable(v3))
    else $error("pipeline moved during a stall");

endmodule

/* hdl/ofd_norm.sv */
`timescale 1ns / 1ps
// Pipelined 3-vector normalizer: block shift, squares, bit-serial isqrt,
// three bit-serial dividers. Depends on ofd_pkg.
module ofd_norm #(
  parameter int MW = ofd_pkg::DIR_W,
  parameter int SW = 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 vld_in,
  input  logic [2:0]                           neg_in,
  input  logic [2:0][MW-1:0]                   mag_in,
  input  logic [SW-1:0]                        side_in,
  output logic                                 vld_out,
  output logic [2:0]                           neg_out,
  output logic [2:0][ofd_pkg::RED_W-1:0]       red_out,
  output logic [2:0][ofd_pkg::Q_W-1:0]         q_out,
  output logic [SW-1:0]                        side_out
);
  import ofd_pkg::*;

  localparam int XW      = MW - RED_W;
  localparam int SHW     = $clog2(XW + 1);
  localparam int RT_W    = RED_W + 1;
  localparam int SQ_W    = 2 * RT_W;
  localparam int RM_W    = RT_W + 2;
  localparam int DEN_W   = RT_W + 1;
  localparam int NUM_W   = RED_W + QW + 1;
  localparam int ST_C    = 2;
  localparam int ST_E    = 4;
  localparam int ST_SQ0  = 5;
  localparam int ST_PREP = ST_SQ0 + RT_W;
  localparam int ST_DV0  = ST_PREP + 1;
  localparam int ST_OUT  = ST_DV0 + QW;
  localparam int NST     = ST_OUT + 1;

  logic                  vld [NST];
  logic [2:0]            ng  [NST];
  logic [SW-1:0]         sd  [NST];
  logic [2:0][RED_W-1:0] rr  [ST_C:NST-1];

  logic [2:0][MW-1:0]    mag0, mag1;
  logic [XW-1:0]         hi0, hi_next;
  logic [SHW-1:0]        s1, s_next;
  logic [2:0][RED_W-1:0] r_next;
  logic [2:0][PROD_W-1:0] sq3, sq_next;
  logic [SQ_W-1:0]       sum_next;

  logic [SQ_W-1:0]       xs       [ST_E:ST_PREP-1];
  logic [RM_W-1:0]       rem      [ST_E:ST_PREP-1];
  logic [RT_W-1:0]       rt       [ST_E:ST_PREP-1];
  logic [SQ_W-1:0]       xs_next  [ST_SQ0:ST_PREP-1];
  logic [RM_W-1:0]       rem_next [ST_SQ0:ST_PREP-1];
  logic [RT_W-1:0]       rt_next  [ST_SQ0:ST_PREP-1];

  logic [DEN_W-1:0]      den      [ST_PREP:ST_OUT-1];
  logic [2:0][NUM_W-1:0] dr       [ST_PREP:ST_OUT-1];
  logic [2:0][QW-1:0]    qq       [ST_PREP:ST_OUT-1];
  logic [2:0][NUM_W-1:0] dr_next  [ST_DV0:ST_OUT-1];
  logic [2:0][QW-1:0]    qq_next  [ST_DV0:ST_OUT-1];
  logic [2:0][Q_W-1:0]   qo, qo_next;

  // Bit length of the OR of the high parts equals that of the max.
  always_comb begin
    hi_next = mag_in[0][MW-1:RED_W] | mag_in[1][MW-1:RED_W] | mag_in[2][MW-1:RED_W];
  end

  always_comb begin
    s_next = '0;
    for (int i = 0; i < XW; i++) begin
      if (hi0[i]) s_next = SHW'(i + 1);
    end
  end

  always_comb begin
    logic [MW-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      sh        = mag1[i] >> s1;
      r_next[i] = sh[RED_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_next[i] = PROD_W'(rr[ST_C][i]) * PROD_W'(rr[ST_C][i]);
    end
    sum_next = SQ_W'(sq3[0]) + SQ_W'(sq3[1]) + SQ_W'(sq3[2]);
  end

  // One root bit per stage (restoring digit recurrence).
  always_comb begin
    logic [RM_W-1:0] cand;
    logic [RM_W-1:0] trial;
    for (int j = 0; j < RT_W; j++) begin
      cand  = {rem[ST_SQ0+j-1][RM_W-3:0], xs[ST_SQ0+j-1][SQ_W-1 -: 2]};
      trial = {rt[ST_SQ0+j-1], 2'b01};
      if (cand >= trial) begin
        rem_next[ST_SQ0+j] = cand - trial;
        rt_next[ST_SQ0+j]  = {rt[ST_SQ0+j-1][RT_W-2:0], 1'b1};
      end else begin
        rem_next[ST_SQ0+j] = cand;
        rt_next[ST_SQ0+j]  = {rt[ST_SQ0+j-1][RT_W-2:0], 1'b0};
      end
      xs_next[ST_SQ0+j] = xs[ST_SQ0+j-1] << 2;
    end
  end

  // One quotient bit per stage, MSB first.
  always_comb begin
    logic [NUM_W-1:0] dv;
    for (int d = 0; d < QW; d++) begin
      dv = NUM_W'(den[ST_DV0+d-1]);
      for (int i = 0; i < 3; i++) begin
        if ((dr[ST_DV0+d-1][i] >> (QW - 1 - d)) >= dv) begin
          dr_next[ST_DV0+d][i] = dr[ST_DV0+d-1][i] - (dv << (QW - 1 - d));
          qq_next[ST_DV0+d][i] = qq[ST_DV0+d-1][i] | (QW'(1) << (QW - 1 - d));
        end else begin
          dr_next[ST_DV0+d][i] = dr[ST_DV0+d-1][i];
          qq_next[ST_DV0+d][i] = qq[ST_DV0+d-1][i];
        end
      end
    end
  end

  always_comb begin
    logic [Q_W-1:0] qe;
    for (int i = 0; i < 3; i++) begin
      qe         = {1'b0, qq[ST_OUT-1][i]};
      qo_next[i] = ng[ST_OUT-1][i] ? -qe : qe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NST; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= vld_in;
      for (int k = 1; k < NST; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ng[0]   <= neg_in;
      sd[0]   <= side_in;
      for (int k = 1; k < NST; k++) begin
        ng[k] <= ng[k-1];
        sd[k] <= sd[k-1];
      end
      mag0     <= mag_in;
      hi0      <= hi_next;
      mag1     <= mag0;
      s1       <= s_next;
      rr[ST_C] <= r_next;
      for (int k = ST_C + 1; k < NST; k++) rr[k] <= rr[k-1];
      sq3      <= sq_next;
      xs[ST_E]  <= sum_next;
      rem[ST_E] <= '0;
      rt[ST_E]  <= '0;
      for (int k = ST_SQ0; k < ST_PREP; k++) begin
        xs[k]  <= xs_next[k];
        rem[k] <= rem_next[k];
        rt[k]  <= rt_next[k];
      end
      den[ST_PREP] <= {rt[ST_PREP-1], 1'b0};
      qq[ST_PREP]  <= '0;
      for (int i = 0; i < 3; i++) begin
        dr[ST_PREP][i] <= NUM_W'({rr[ST_PREP-1][i], QW'(0)}) + NUM_W'(rt[ST_PREP-1]);
      end
      for (int k = ST_DV0; k < ST_OUT; k++) begin
        den[k] <= den[k-1];
        dr[k]  <= dr_next[k];
        qq[k]  <= qq_next[k];
      end
      qo <= qo_next;
    end
  end

  assign vld_out  = vld[NST-1];
  assign neg_out  = ng[NST-1];
  assign red_out  = rr[NST-1];
  assign q_out    = qo;
  assign side_out = sd[NST-1];

endmodule
